@@ hdl/fhp_pkg.sv @@
package fhp_pkg;

    localparam int unsigned ALIGN_BYTES = 64;
    localparam int unsigned OFFSET_W    = $clog2(ALIGN_BYTES);
    localparam int unsigned PREAMBLE_N  = 4;

    localparam logic [7:0]          MARKER_BYTE = 8'h5A;
    localparam logic [OFFSET_W-1:0] OFFSET_WRAP = 6'h3F;

    localparam logic OP_START = 1'b0;
    localparam logic OP_DATA  = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_HDR,
        S_PAD
    } t_state;

    typedef enum logic [2:0] {
        SEL_MARK,
        SEL_HDR,
        SEL_DATA,
        SEL_ZERO,
        SEL_ERR
    } t_sel;

    typedef struct packed {
        logic in_ready;
        logic start;
        logic emit;
        t_sel sel;
        logic run_last;
        logic frame_end;
        logic set_open;
        logic close;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic in_op;
        logic slot_free;
        logic frame_open;
        logic last_payload;
        logic align_wrap;
        logic hdr_last;
        logic len_zero;
    } t_status;

endpackage

@@ hdl/fhp_in_if.sv @@
interface fhp_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [11:0] frame_length;
    logic [31:0] frame_id;
    logic [7:0]  data_byte;

    modport source (output valid, op, frame_length, frame_id, data_byte, input ready);
    modport sink   (input valid, op, frame_length, frame_id, data_byte, output ready);
endinterface

@@ hdl/fhp_out_if.sv @@
interface fhp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_end;
    logic       error;

    modport source (output valid, out_byte, run_last, frame_end, error, input ready);
    modport sink   (input valid, out_byte, run_last, frame_end, error, output ready);
endinterface

@@ hdl/fhp_ctrl.sv @@
module fhp_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  fhp_pkg::t_status i_status,
    output fhp_pkg::t_cmd    o_cmd
);

    fhp_pkg::t_state r_state;
    fhp_pkg::t_state n_state;
    logic            w_accept;

    assign w_accept = i_status.in_valid && i_status.slot_free && (r_state == fhp_pkg::S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fhp_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            fhp_pkg::S_IDLE: begin
                if (w_accept) begin
                    if (i_status.in_op == fhp_pkg::OP_START) begin
                        n_state = fhp_pkg::S_HDR;
                    end else if (i_status.frame_open && i_status.last_payload &&
                                 !i_status.align_wrap) begin
                        n_state = fhp_pkg::S_PAD;
                    end
                end
            end
            fhp_pkg::S_HDR: begin
                if (i_status.slot_free && i_status.hdr_last) begin
                    if (i_status.len_zero && !i_status.align_wrap) begin
                        n_state = fhp_pkg::S_PAD;
                    end else begin
                        n_state = fhp_pkg::S_IDLE;
                    end
                end
            end
            fhp_pkg::S_PAD: begin
                if (i_status.slot_free && i_status.align_wrap) begin
                    n_state = fhp_pkg::S_IDLE;
                end
            end
            default: n_state = fhp_pkg::S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd = '0;
        o_cmd.sel = fhp_pkg::SEL_ZERO;
        case (r_state)
            fhp_pkg::S_IDLE: begin
                o_cmd.in_ready = i_status.slot_free;
                if (w_accept) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.in_op == fhp_pkg::OP_START) begin
                        o_cmd.sel   = fhp_pkg::SEL_MARK;
                        o_cmd.start = 1'b1;
                    end else if (!i_status.frame_open) begin
                        o_cmd.sel      = fhp_pkg::SEL_ERR;
                        o_cmd.run_last = 1'b1;
                    end else begin
                        o_cmd.sel = fhp_pkg::SEL_DATA;
                        if (!i_status.last_payload) begin
                            o_cmd.run_last = 1'b1;
                        end else if (i_status.align_wrap) begin
                            o_cmd.run_last  = 1'b1;
                            o_cmd.frame_end = 1'b1;
                            o_cmd.close     = 1'b1;
                        end
                    end
                end
            end
            fhp_pkg::S_HDR: begin
                if (i_status.slot_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.sel  = fhp_pkg::SEL_HDR;
                    if (i_status.hdr_last) begin
                        if (!i_status.len_zero) begin
                            o_cmd.set_open = 1'b1;
                            o_cmd.run_last = 1'b1;
                        end else if (i_status.align_wrap) begin
                            o_cmd.run_last  = 1'b1;
                            o_cmd.frame_end = 1'b1;
                            o_cmd.close     = 1'b1;
                        end
                    end
                end
            end
            fhp_pkg::S_PAD: begin
                if (i_status.slot_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.sel  = fhp_pkg::SEL_ZERO;
                    if (i_status.align_wrap) begin
                        o_cmd.run_last  = 1'b1;
                        o_cmd.frame_end = 1'b1;
                        o_cmd.close     = 1'b1;
                    end
                end
            end
            default: o_cmd = '0;
        endcase
    end

    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_status.in_valid && o_cmd.in_ready) |-> (r_state == fhp_pkg::S_IDLE))
        else $error("item taken outside idle");
    a_start_to_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start |=> (r_state == fhp_pkg::S_HDR))
        else $error("start did not enter header run");
    a_close_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.close |-> (o_cmd.run_last && o_cmd.frame_end))
        else $error("frame closed without end marking");

endmodule

@@ hdl/fhp_datapath.sv @@
module fhp_datapath #(
    parameter int unsigned HEADER_GAP = 54
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    fhp_in_if.sink            i_in,
    fhp_out_if.source         o_out,
    input  fhp_pkg::t_cmd     i_cmd,
    output fhp_pkg::t_status  o_status
);

    localparam int unsigned OW = fhp_pkg::OFFSET_W;
    localparam logic [OW-1:0] LEN_LO_POS = OW'(fhp_pkg::PREAMBLE_N);
    localparam logic [OW-1:0] LEN_HI_POS = OW'(fhp_pkg::PREAMBLE_N + 1);
    localparam logic [OW-1:0] ID_POS     = OW'(fhp_pkg::PREAMBLE_N + 2 + HEADER_GAP);
    localparam logic [OW-1:0] HDR_LAST   = OW'(fhp_pkg::PREAMBLE_N + 5 + HEADER_GAP);

    logic [11:0]   r_len;
    logic [31:0]   r_id;
    logic [11:0]   r_bytes_left;
    logic          r_frame_open;
    logic [OW-1:0] r_align;

    logic          r_out_valid;
    logic [7:0]    r_out_byte;
    logic          r_out_run_last;
    logic          r_out_frame_end;
    logic          r_out_error;

    logic [7:0]    w_hdr_byte;
    logic [7:0]    w_byte;
    logic [OW-1:0] w_id_rel;

    assign w_id_rel = r_align - ID_POS;

    // header byte at the current offset
    always_comb begin
        w_hdr_byte = 8'h00;
        if (r_align < LEN_LO_POS) begin
            w_hdr_byte = fhp_pkg::MARKER_BYTE;
        end else if (r_align == LEN_LO_POS) begin
            w_hdr_byte = r_len[7:0];
        end else if (r_align == LEN_HI_POS) begin
            w_hdr_byte = {4'h0, r_len[11:8]};
        end else if (r_align >= ID_POS) begin
            case (w_id_rel[1:0])
                2'd0:    w_hdr_byte = r_id[7:0];
                2'd1:    w_hdr_byte = r_id[15:8];
                2'd2:    w_hdr_byte = r_id[23:16];
                default: w_hdr_byte = r_id[31:24];
            endcase
        end
    end

    always_comb begin
        case (i_cmd.sel)
            fhp_pkg::SEL_MARK: w_byte = fhp_pkg::MARKER_BYTE;
            fhp_pkg::SEL_HDR:  w_byte = w_hdr_byte;
            fhp_pkg::SEL_DATA: w_byte = i_in.data_byte;
            default:           w_byte = 8'h00;
        endcase
    end

    assign i_in.ready = i_cmd.in_ready;

    assign o_status.in_valid     = i_in.valid;
    assign o_status.in_op        = i_in.op;
    assign o_status.slot_free    = !r_out_valid || o_out.ready;
    assign o_status.frame_open   = r_frame_open;
    assign o_status.last_payload = (r_bytes_left == 12'd1);
    assign o_status.align_wrap   = (r_align == fhp_pkg::OFFSET_WRAP);
    assign o_status.hdr_last     = (r_align == HDR_LAST);
    assign o_status.len_zero     = (r_len == 12'd0);

    // frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_left <= '0;
            r_frame_open <= 1'b0;
            r_align      <= '0;
        end else begin
            if (i_cmd.start) begin
                r_align <= OW'(1);
            end else if (i_cmd.emit && (i_cmd.sel != fhp_pkg::SEL_ERR)) begin
                r_align <= r_align + OW'(1);
            end
            if (i_cmd.start || i_cmd.close) begin
                r_frame_open <= 1'b0;
            end else if (i_cmd.set_open) begin
                r_frame_open <= 1'b1;
            end
            if (i_cmd.close) begin
                r_bytes_left <= '0;
            end else if (i_cmd.set_open) begin
                r_bytes_left <= r_len;
            end else if (i_cmd.emit && (i_cmd.sel == fhp_pkg::SEL_DATA)) begin
                r_bytes_left <= r_bytes_left - 12'd1;
            end
        end
    end

    // captured start fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_len <= i_in.frame_length;
            r_id  <= i_in.frame_id;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_byte      <= w_byte;
            r_out_run_last  <= i_cmd.run_last;
            r_out_frame_end <= i_cmd.frame_end;
            r_out_error     <= (i_cmd.sel == fhp_pkg::SEL_ERR);
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.out_byte  = r_out_byte;
    assign o_out.run_last  = r_out_run_last;
    assign o_out.frame_end = r_out_frame_end;
    assign o_out.error     = r_out_error;

    a_end_on_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && i_cmd.frame_end) |-> (r_align == fhp_pkg::OFFSET_WRAP))
        else $error("frame end off the alignment boundary");
    a_closed_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && i_cmd.frame_end) |=> (!r_frame_open && r_align == '0))
        else $error("frame still open after its end");
    a_err_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_error) |-> (r_out_run_last && !r_out_frame_end))
        else $error("error result with bad flags");

endmodule

@@ hdl/frame_header_pad_64b.sv @@
// An item's first result is registered and shows in the cycle after the item is taken.
// A payload item yields one byte; a start item yields 10 + HEADER_GAP header bytes, one
//   header byte a cycle from the byte sequencer while the output is not stalled, and
//   a frame close adds zero pad bytes up to the next 64-byte boundary (up to 63).
// A new item is taken only once the sequencer has finished the previous one's run.
// Reset (synchronous, active low) closes any open frame and empties the output register.
module frame_header_pad_64b #(
    parameter int unsigned HEADER_GAP = 54
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fhp_in_if.sink    i_in,
    fhp_out_if.source o_out
);

    // Command and status between the sequencer and the byte datapath.
    fhp_pkg::t_cmd    w_cmd;
    fhp_pkg::t_status w_status;

    // Sequencer: idle, header run, pad run. Takes an item only in idle and
    // only when the output register can accept a byte in the same cycle.
    fhp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    // Datapath: holds the frame state (bytes left, open flag, offset within
    // the 64-byte block), forms header bytes from the captured length and id,
    // and registers every result, though the input ready still follows the output
    // ready combinationally through the free-slot test.
    fhp_datapath #(
        .HEADER_GAP (HEADER_GAP)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .o_out    (o_out),
        .i_cmd    (w_cmd),
        .o_status (w_status)
    );

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

    localparam int unsigned HDR_GAP      = 54;
    localparam int          IDLE_LIMIT   = 2000;
    localparam int          DRAIN_CYCLES = 80;
    localparam int          HOLD_OFF_LEN = 400;
    localparam int          RANDOM_ITEMS = 110;

    // One byte of the framed stream as the block should present it
    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       frame_end;
        logic       error;
    } t_framed_byte;

    logic i_clk;
    logic i_rst_n;

    fhp_in_if  in_bus ();
    fhp_out_if out_bus ();

    frame_header_pad_64b #(
        .HEADER_GAP(HDR_GAP)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_bus),
        .o_out  (out_bus)
    );

    // Framer state as the predictor tracks it
    logic [11:0] payload_left;
    logic        frame_is_open;
    logic [5:0]  frame_offset;

    // Bytes still owed by the block, oldest at the front
    t_framed_byte expected_bytes[$];

    int mismatch_count  = 0;
    int items_sent      = 0;
    int idle_cycles     = 0;
    int hold_off_cycles = 0;
    bit src_gap_en      = 1'b1;
    bit sink_stall_en   = 1'b1;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        if ($urandom_range(0, 15) == 0) begin
            return $urandom_range(10, 40);
        end
        return $urandom_range(1, 3);
    endfunction

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Queue one byte; framed bytes advance the position within the 64-byte block
    function automatic void emit_byte(input logic [7:0] b, input logic err,
                                      input logic framed);
        t_framed_byte r;
        r.out_byte  = b;
        r.run_last  = 1'b0;
        r.frame_end = 1'b0;
        r.error     = err;
        expected_bytes.push_back(r);
        if (framed) begin
            frame_offset = frame_offset + 6'd1;
        end
    endfunction

    // Pad with zeroes up to the next boundary and flag the final byte
    function automatic void close_frame_bytes();
        t_framed_byte r;
        while (frame_offset != 6'd0) begin
            emit_byte(8'h00, 1'b0, 1'b1);
        end
        r = expected_bytes.pop_back();
        r.frame_end = 1'b1;
        expected_bytes.push_back(r);
        frame_is_open = 1'b0;
        payload_left  = 12'd0;
    endfunction

    function automatic void predict_framer(input logic op, input logic [11:0] len,
                                           input logic [31:0] id, input logic [7:0] db);
        t_framed_byte r;
        if (op == fhp_pkg::OP_START) begin
            // A start always begins a fresh frame; any open frame is dropped unpadded
            frame_offset = 6'd0;
            repeat (fhp_pkg::PREAMBLE_N) emit_byte(fhp_pkg::MARKER_BYTE, 1'b0, 1'b1);
            emit_byte(len[7:0], 1'b0, 1'b1);
            emit_byte({4'h0, len[11:8]}, 1'b0, 1'b1);
            repeat (HDR_GAP) emit_byte(8'h00, 1'b0, 1'b1);
            for (int i = 0; i < 4; i++) begin
                emit_byte(id[8*i +: 8], 1'b0, 1'b1);
            end
            if (len == 12'd0) begin
                close_frame_bytes();
            end else begin
                frame_is_open = 1'b1;
                payload_left  = len;
            end
        end else if (!frame_is_open) begin
            // Payload with nowhere to go: one error byte, state untouched
            emit_byte(8'h00, 1'b1, 1'b0);
        end else begin
            emit_byte(db, 1'b0, 1'b1);
            payload_left = payload_left - 12'd1;
            if (payload_left == 12'd0) begin
                close_frame_bytes();
            end
        end
        r = expected_bytes.pop_back();
        r.run_last = 1'b1;
        expected_bytes.push_back(r);
    endfunction

    // ------------------------------------------------------------------
    // Sender: drive at the falling edge, see acceptance at the rising edge
    // ------------------------------------------------------------------

    task automatic send_item(input logic op, input logic [11:0] len,
                             input logic [31:0] id, input logic [7:0] db);
        int gap;
        gap = 0;
        if (src_gap_en && $urandom_range(0, 2) == 0) begin
            gap = pick_gap();
        end
        @(negedge i_clk);
        if (gap > 0) begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_bus.valid        <= 1'b1;
        in_bus.op           <= op;
        in_bus.frame_length <= len;
        in_bus.frame_id     <= id;
        in_bus.data_byte    <= db;
        // Hold the item until the block takes it
        forever begin
            @(posedge i_clk);
            if (in_bus.ready) begin
                break;
            end
        end
        predict_framer(op, len, id, db);
        items_sent++;
    endtask

    // Unused fields carry noise so that the block is seen to ignore them
    task automatic send_start(input logic [11:0] len, input logic [31:0] id);
        send_item(fhp_pkg::OP_START, len, id, 8'($urandom));
    endtask

    task automatic send_data(input logic [7:0] db);
        send_item(fhp_pkg::OP_DATA, 12'($urandom), $urandom, db);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus a long hold-off on request
    // ------------------------------------------------------------------

    initial begin : result_sink
        int stall;
        out_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            stall = 0;
            if (hold_off_cycles > 0) begin
                stall = hold_off_cycles;
                hold_off_cycles = 0;
            end else if (sink_stall_en && $urandom_range(0, 3) == 0) begin
                stall = pick_gap();
            end
            if (stall > 0) begin
                out_bus.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_bus.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %02h, actual %02h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_framed_byte want;
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            if (expected_bytes.size() == 0) begin
                $display("%0t: unexpected byte, expected none, actual %02h (last %b end %b err %b)",
                         $time, out_bus.out_byte, out_bus.run_last, out_bus.frame_end,
                         out_bus.error);
                mismatch_count++;
            end else begin
                want = expected_bytes.pop_front();
                check_field("out_byte", want.out_byte, out_bus.out_byte);
                check_field("run_last", 8'(want.run_last), 8'(out_bus.run_last));
                check_field("frame_end", 8'(want.frame_end), 8'(out_bus.frame_end));
                check_field("error", 8'(want.error), 8'(out_bus.error));
            end
        end
    end

    // Give up once nothing has moved on either side for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Payload straight after reset has no frame to join
    task automatic test_orphan_after_reset();
        send_data(8'hFF);
        send_data(8'h00);
    endtask

    // Header alone, padded already, with the id at both extremes
    task automatic test_empty_frame();
        send_start(12'd0, 32'hFFFF_FFFF);
        send_start(12'd0, 32'h0000_0000);
    endtask

    // One payload byte leaves 63 bytes of padding; payload after close is an error
    task automatic test_short_frame();
        send_start(12'd1, 32'hA5C3_0F96);
        send_data(8'hFF);
        send_data(8'h5A);
    endtask

    // Longest length, left open and then cut off by a fresh start
    task automatic test_abandoned_frame();
        send_start(12'd4095, 32'h8000_0001);
        send_data(8'h00);
        send_data(8'hFF);
        send_data(8'h81);
        send_start(12'd2, 32'h0000_FFFF);
        send_data(8'h7E);
        send_data(8'h01);
        send_data(8'h33);
    endtask

    // Hold the receiver off while a frame of 64 payload bytes streams in: the block must fill and
    // stall its input; the frame closes on its last payload byte with no padding
    task automatic test_pressure_aligned_frame();
        src_gap_en      = 1'b0;
        hold_off_cycles = HOLD_OFF_LEN;
        send_start(12'd64, $urandom);
        repeat (64) send_data(8'($urandom));
        src_gap_en = 1'b1;
    endtask

    // Lengths mostly short, some near or at the boundary, some empty
    function automatic logic [11:0] pick_length();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) begin
            return 12'd0;
        end else if (r == 1) begin
            return 12'd64;
        end else if (r == 2) begin
            return 12'($urandom_range(60, 70));
        end
        return 12'($urandom_range(1, 12));
    endfunction

    task automatic test_random_traffic();
        int          start_count;
        int          kind;
        int          n_bytes;
        logic [11:0] len;
        start_count = items_sent;
        while (items_sent - start_count < RANDOM_ITEMS) begin
            // Vary the idling so that some stretches run flat out
            src_gap_en    = ($urandom_range(0, 3) != 0);
            sink_stall_en = ($urandom_range(0, 3) != 0);
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
                len = pick_length();
                send_start(len, $urandom);
                repeat (len) send_data(8'($urandom));
            end else if (kind == 7) begin
                // A length from 2 up to 4095, mostly cut short; the next start or payload decides its fate
                len = 12'($urandom_range(2, 4095));
                send_start(len, $urandom);
                n_bytes = $urandom_range(0, 5);
                repeat (n_bytes) send_data(8'($urandom));
            end else begin
                n_bytes = $urandom_range(1, 3);
                repeat (n_bytes) send_data(8'($urandom));
            end
        end
        src_gap_en    = 1'b1;
        sink_stall_en = 1'b1;
    endtask

    initial begin : run_tests
        in_bus.valid        = 1'b0;
        in_bus.op           = fhp_pkg::OP_START;
        in_bus.frame_length = '0;
        in_bus.frame_id     = '0;
        in_bus.data_byte    = '0;
        payload_left        = '0;
        frame_is_open       = 1'b0;
        frame_offset        = '0;
        i_rst_n             = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_orphan_after_reset();
        test_empty_frame();
        test_short_frame();
        test_abandoned_frame();
        test_pressure_aligned_frame();
        test_random_traffic();

        @(negedge i_clk);
        in_bus.valid <= 1'b0;
        // Drain what is owed, then allow time for any stray byte to show
        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hdl/fhp_pkg.sv
hdl/fhp_in_if.sv
hdl/fhp_out_if.sv
hdl/fhp_ctrl.sv
hdl/fhp_datapath.sv
hdl/frame_header_pad_64b.sv
tb/sv/testbench.sv
